@@ rtl/rcq_pkg.sv @@
// ----------------------------------------------------------------------------
// rcq_pkg: shared types and constants
// Palette codes, expansion constants and pipeline enable bundle for the
// RGB565 six-color quantizer.
// ----------------------------------------------------------------------------
package rcq_pkg;

	typedef logic [2:0]  pal_idx_t;
	typedef logic [22:0] dist_t;
	typedef logic [7:0]  chan_t;
	typedef logic [15:0] sq_t;

	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
		logic s5;
	} stage_en_t;

	localparam pal_idx_t PAL_BLACK  = 3'd0;
	localparam pal_idx_t PAL_WHITE  = 3'd1;
	localparam pal_idx_t PAL_YELLOW = 3'd2;
	localparam pal_idx_t PAL_RED    = 3'd3;
	localparam pal_idx_t PAL_BLUE   = 3'd4;
	localparam pal_idx_t PAL_GREEN  = 3'd5;

	localparam logic [23:0] CODE_MAP_RESET = 24'h653210;

	localparam logic [15:0] EXP5_MUL = 16'd527;
	localparam logic [15:0] EXP5_ADD = 16'd23;
	localparam logic [15:0] EXP6_MUL = 16'd259;
	localparam logic [15:0] EXP6_ADD = 16'd33;

	localparam dist_t WEIGHT_R = 23'd30;
	localparam dist_t WEIGHT_G = 23'd59;
	localparam dist_t WEIGHT_B = 23'd11;

	localparam chan_t CHAN_FULL = 8'hFF;

endpackage

@@ rtl/rcq_color.sv @@
// ----------------------------------------------------------------------------
// rcq_color: channel expansion and weighted squared terms
// Stage 1 widens the channels to 8 bits, stage 2 squares the distance of each
// channel to 0 and to 255, stage 3 applies the 30/59/11 weights.
// ----------------------------------------------------------------------------
module rcq_color
	import rcq_pkg::*;
(
	input  logic        clk,
	input  stage_en_t   en,
	input  logic [15:0] pixel_rgb565,
	output dist_t       wr_lo_s3,
	output dist_t       wr_hi_s3,
	output dist_t       wg_lo_s3,
	output dist_t       wg_hi_s3,
	output dist_t       wb_lo_s3,
	output dist_t       wb_hi_s3
);

	logic [15:0] r_full, g_full, b_full;
	chan_t       r_s1, g_s1, b_s1;
	sq_t         r_lo_s2, r_hi_s2, g_lo_s2, g_hi_s2, b_lo_s2, b_hi_s2;
	chan_t       r_inv, g_inv, b_inv;

	assign r_full = {11'd0, pixel_rgb565[15:11]} * EXP5_MUL + EXP5_ADD;
	assign g_full = {10'd0, pixel_rgb565[10:5]} * EXP6_MUL + EXP6_ADD;
	assign b_full = {11'd0, pixel_rgb565[4:0]} * EXP5_MUL + EXP5_ADD;

	assign r_inv = CHAN_FULL - r_s1;
	assign g_inv = CHAN_FULL - g_s1;
	assign b_inv = CHAN_FULL - b_s1;

	always_ff @(posedge clk) begin
		if (en.s1) begin
			r_s1 <= r_full[13:6];
			g_s1 <= g_full[13:6];
			b_s1 <= b_full[13:6];
		end
		if (en.s2) begin
			r_lo_s2 <= {8'd0, r_s1} * {8'd0, r_s1};
			r_hi_s2 <= {8'd0, r_inv} * {8'd0, r_inv};
			g_lo_s2 <= {8'd0, g_s1} * {8'd0, g_s1};
			g_hi_s2 <= {8'd0, g_inv} * {8'd0, g_inv};
			b_lo_s2 <= {8'd0, b_s1} * {8'd0, b_s1};
			b_hi_s2 <= {8'd0, b_inv} * {8'd0, b_inv};
		end
		if (en.s3) begin
			wr_lo_s3 <= {7'd0, r_lo_s2} * WEIGHT_R;
			wr_hi_s3 <= {7'd0, r_hi_s2} * WEIGHT_R;
			wg_lo_s3 <= {7'd0, g_lo_s2} * WEIGHT_G;
			wg_hi_s3 <= {7'd0, g_hi_s2} * WEIGHT_G;
			wb_lo_s3 <= {7'd0, b_lo_s2} * WEIGHT_B;
			wb_hi_s3 <= {7'd0, b_hi_s2} * WEIGHT_B;
		end
	end

endmodule

@@ rtl/rcq_select.sv @@
// ----------------------------------------------------------------------------
// rcq_select: palette distance and nearest-color pick
// Stage 4 forms the six distances and keeps the winner of each pair, stage 5
// merges the pairs, lower index on ties, and looks up the panel code.
// ----------------------------------------------------------------------------
module rcq_select
	import rcq_pkg::*;
(
	input  logic        clk,
	input  stage_en_t   en,
	input  logic [23:0] code_map,
	input  dist_t       wr_lo_s3,
	input  dist_t       wr_hi_s3,
	input  dist_t       wg_lo_s3,
	input  dist_t       wg_hi_s3,
	input  dist_t       wb_lo_s3,
	input  dist_t       wb_hi_s3,
	output pal_idx_t    idx_s5,
	output logic [3:0]  code_s5
);

	dist_t    d_black, d_white, d_yellow, d_red, d_blue, d_green;
	dist_t    da_s4, db_s4, dc_s4;
	pal_idx_t ia_s4, ib_s4, ic_s4;
	dist_t    dab;
	pal_idx_t iab, iabc;
	logic [3:0] code_sel;

	assign d_black  = wr_lo_s3 + wg_lo_s3 + wb_lo_s3;
	assign d_white  = wr_hi_s3 + wg_hi_s3 + wb_hi_s3;
	assign d_yellow = wr_hi_s3 + wg_hi_s3 + wb_lo_s3;
	assign d_red    = wr_hi_s3 + wg_lo_s3 + wb_lo_s3;
	assign d_blue   = wr_lo_s3 + wg_lo_s3 + wb_hi_s3;
	assign d_green  = wr_lo_s3 + wg_hi_s3 + wb_lo_s3;

	always_ff @(posedge clk) begin
		if (en.s4) begin
			if (d_white < d_black) begin
				da_s4 <= d_white;
				ia_s4 <= PAL_WHITE;
			end else begin
				da_s4 <= d_black;
				ia_s4 <= PAL_BLACK;
			end
			if (d_red < d_yellow) begin
				db_s4 <= d_red;
				ib_s4 <= PAL_RED;
			end else begin
				db_s4 <= d_yellow;
				ib_s4 <= PAL_YELLOW;
			end
			if (d_green < d_blue) begin
				dc_s4 <= d_green;
				ic_s4 <= PAL_GREEN;
			end else begin
				dc_s4 <= d_blue;
				ic_s4 <= PAL_BLUE;
			end
		end
	end

	always_comb begin
		if (db_s4 < da_s4) begin
			dab = db_s4;
			iab = ib_s4;
		end else begin
			dab = da_s4;
			iab = ia_s4;
		end
		iabc = (dc_s4 < dab) ? ic_s4 : iab;
		case (iabc)
			PAL_BLACK:  code_sel = code_map[3:0];
			PAL_WHITE:  code_sel = code_map[7:4];
			PAL_YELLOW: code_sel = code_map[11:8];
			PAL_RED:    code_sel = code_map[15:12];
			PAL_BLUE:   code_sel = code_map[19:16];
			PAL_GREEN:  code_sel = code_map[23:20];
			default:    code_sel = code_map[3:0];
		endcase
	end

	always_ff @(posedge clk) begin
		if (en.s5) begin
			idx_s5  <= iabc;
			code_s5 <= code_sel;
		end
	end

endmodule

@@ rtl/rcq_addr.sv @@
// ----------------------------------------------------------------------------
// rcq_addr: rotated packed-nibble address
// Stage 1 rotates the coordinates and scales the row, stage 2 adds the column
// byte; stages 3 to 5 carry the result alongside the color path.
// ----------------------------------------------------------------------------
module rcq_addr
	import rcq_pkg::*;
#(
	parameter int FB_WIDTH  = 1024,
	parameter int FB_HEIGHT = 2048
) (
	input  logic        clk,
	input  stage_en_t   en,
	input  logic [10:0] screen_x,
	input  logic [9:0]  screen_y,
	output logic [19:0] addr_s5,
	output logic        hi_s5
);

	localparam logic [19:0] ROW_BYTES = 20'(FB_WIDTH / 2);
	localparam logic [19:0] FY_TOP    = 20'(FB_HEIGHT - 1);

	logic [19:0] fy;
	logic [19:0] row_s1;
	logic [8:0]  col_s1;
	logic        hi_s1, hi_s2, hi_s3, hi_s4;
	logic [19:0] addr_s2, addr_s3, addr_s4;

	assign fy = FY_TOP - {9'd0, screen_x};

	always_ff @(posedge clk) begin
		if (en.s1) begin
			row_s1 <= fy * ROW_BYTES;
			col_s1 <= screen_y[9:1];
			hi_s1  <= ~screen_y[0];
		end
		if (en.s2) begin
			addr_s2 <= row_s1 + {11'd0, col_s1};
			hi_s2   <= hi_s1;
		end
		if (en.s3) begin
			addr_s3 <= addr_s2;
			hi_s3   <= hi_s2;
		end
		if (en.s4) begin
			addr_s4 <= addr_s3;
			hi_s4   <= hi_s3;
		end
		if (en.s5) begin
			addr_s5 <= addr_s4;
			hi_s5   <= hi_s4;
		end
	end

endmodule

@@ rtl/rgb565_six_color_quantize_pack.sv @@
// ----------------------------------------------------------------------------
// rgb565_six_color_quantize_pack: six-color quantizer with nibble addressing
// Maps an RGB565 pixel to the nearest of six palette colors, picks its panel
// code and gives the rotated framebuffer byte address and nibble half.
//
//   port group   dir  handshake             contents
//   in_*         in   in_valid / in_ready   pixel_rgb565, screen_x, screen_y
//   out_*        out  out_valid / out_ready byte_address, high_nibble,
//                                           color_code, palette_index
//   cfg_*        in   cfg_wr_en             cfg_wr_data -> code_map
//
// Five register stages, s1 to s5, carry each pixel from its transfer to the
// output; one pixel per cycle is sustained while out_ready is high. Each stage
// advances when it is empty or the stage after it advances, so a stalled
// output holds the tail while upstream bubbles still fill. Reset clears the
// valid bits and restores code_map.
// ----------------------------------------------------------------------------
module rgb565_six_color_quantize_pack
	import rcq_pkg::*;
#(
	parameter int FB_WIDTH  = 1024,
	parameter int FB_HEIGHT = 2048
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [15:0] pixel_rgb565,
	input  logic [10:0] screen_x,
	input  logic [9:0]  screen_y,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [19:0] byte_address,
	output logic        high_nibble,
	output logic [3:0]  color_code,
	output logic [2:0]  palette_index,
	input  logic        cfg_wr_en,
	input  logic [23:0] cfg_wr_data
);

	logic [23:0] code_map_q;
	logic        v1_s1, v2_s2, v3_s3, v4_s4, v5_s5;
	logic        adv1, adv2, adv3, adv4, adv5;
	stage_en_t   en;
	dist_t       wr_lo, wr_hi, wg_lo, wg_hi, wb_lo, wb_hi;

	assign adv5 = ~v5_s5 | out_ready;
	assign adv4 = ~v4_s4 | adv5;
	assign adv3 = ~v3_s3 | adv4;
	assign adv2 = ~v2_s2 | adv3;
	assign adv1 = ~v1_s1 | adv2;

	assign en = '{s1: adv1, s2: adv2, s3: adv3, s4: adv4, s5: adv5};

	assign in_ready  = adv1;
	assign out_valid = v5_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1      <= 1'b0;
			v2_s2      <= 1'b0;
			v3_s3      <= 1'b0;
			v4_s4      <= 1'b0;
			v5_s5      <= 1'b0;
			code_map_q <= CODE_MAP_RESET;
		end else begin
			if (adv1) v1_s1 <= in_valid;
			if (adv2) v2_s2 <= v1_s1;
			if (adv3) v3_s3 <= v2_s2;
			if (adv4) v4_s4 <= v3_s3;
			if (adv5) v5_s5 <= v4_s4;
			if (cfg_wr_en) code_map_q <= cfg_wr_data;
		end
	end

	rcq_color u_color (
		.clk          (clk),
		.en           (en),
		.pixel_rgb565 (pixel_rgb565),
		.wr_lo_s3     (wr_lo),
		.wr_hi_s3     (wr_hi),
		.wg_lo_s3     (wg_lo),
		.wg_hi_s3     (wg_hi),
		.wb_lo_s3     (wb_lo),
		.wb_hi_s3     (wb_hi)
	);

	rcq_select u_select (
		.clk      (clk),
		.en       (en),
		.code_map (code_map_q),
		.wr_lo_s3 (wr_lo),
		.wr_hi_s3 (wr_hi),
		.wg_lo_s3 (wg_lo),
		.wg_hi_s3 (wg_hi),
		.wb_lo_s3 (wb_lo),
		.wb_hi_s3 (wb_hi),
		.idx_s5   (palette_index),
		.code_s5  (color_code)
	);

	rcq_addr #(
		.FB_WIDTH  (FB_WIDTH),
		.FB_HEIGHT (FB_HEIGHT)
	) u_addr (
		.clk      (clk),
		.en       (en),
		.screen_x (screen_x),
		.screen_y (screen_y),
		.addr_s5  (byte_address),
		.hi_s5    (high_nibble)
	);

endmodule

@@ rtl/rcq_checker.sv @@
// ----------------------------------------------------------------------------
// rcq_checker: port-level checks for the quantizer
// Tracks code_map from the write port and checks output hold, index range
// and the code lookup.
// ----------------------------------------------------------------------------
module rcq_checker
	import rcq_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic [15:0] pixel_rgb565,
	input logic [10:0] screen_x,
	input logic [9:0]  screen_y,
	input logic        out_valid,
	input logic        out_ready,
	input logic [19:0] byte_address,
	input logic        high_nibble,
	input logic [3:0]  color_code,
	input logic [2:0]  palette_index,
	input logic        cfg_wr_en,
	input logic [23:0] cfg_wr_data
);

	logic [23:0] map_q;
	logic [3:0]  exp_code;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_q <= CODE_MAP_RESET;
		end else if (cfg_wr_en) begin
			map_q <= cfg_wr_data;
		end
	end

	always_comb begin
		case (palette_index)
			PAL_BLACK:  exp_code = map_q[3:0];
			PAL_WHITE:  exp_code = map_q[7:4];
			PAL_YELLOW: exp_code = map_q[11:8];
			PAL_RED:    exp_code = map_q[15:12];
			PAL_BLUE:   exp_code = map_q[19:16];
			PAL_GREEN:  exp_code = map_q[23:20];
			default:    exp_code = 4'd0;
		endcase
	end

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(byte_address)
			&& $stable(high_nibble) && $stable(color_code) && $stable(palette_index))
		else $error("output changed while stalled");

	// valid drops only after a transfer
	a_drop: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(out_valid) |-> $past(out_ready))
		else $error("result dropped without transfer");

	a_index: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> palette_index <= PAL_GREEN)
		else $error("palette index out of range");

	a_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> color_code == exp_code)
		else $error("color code does not match code_map");

endmodule

bind rgb565_six_color_quantize_pack rcq_checker u_rcq_checker (.*);
